// ===== hdl/contiguous_page_allocator_macros.svh =====
// Assertion macros for the contiguous page allocator.
// Used by the top level; depends on nothing else.
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_MACROS_SVH

// Implication checked in the same cycle.
`define CPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Implication checked in the following cycle.
`define CPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// ===== hdl/cpa_pkg.sv =====
// Shared codes for the contiguous page allocator.
// Used by the top level; depends on nothing else.
package cpa_pkg;

    localparam int NEED_W = 25;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_ALLOC = 2'd0;
    localparam logic [1:0] ST_OOM   = 2'd1;
    localparam logic [1:0] ST_FREED = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    localparam logic [1:0] POL_FIRST  = 2'd0;
    localparam logic [1:0] POL_BEST   = 2'd1;
    localparam logic [1:0] POL_WORST  = 2'd2;
    localparam logic [1:0] POL_UNUSED = 2'd3;

endpackage

// ===== hdl/cpa_entry_ram.sv =====
// Block table memory with one write port and one registered read port.
// Entry 0 reads as its reset word until first written; no package needed.
module cpa_entry_ram #(
    parameter int DEPTH = 256,
    parameter int IW = 8,
    parameter int DW = 34,
    parameter logic [DW-1:0] RST_WORD = '0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [IW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;
    logic          e0_vld_reg;
    logic          rd0_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e0_vld_reg <= 1'b0;
            rd0_reg    <= 1'b0;
        end
        else
        begin
            rd0_reg <= (raddr == '0) && !e0_vld_reg;
            if (we && (waddr == '0))
            begin
                e0_vld_reg <= 1'b1;
            end
        end
    end

    assign rdata = rd0_reg ? RST_WORD : rdata_reg;

endmodule

// ===== hdl/contiguous_page_allocator.sv =====
// Contiguous page allocator. An allocate keeps busy at most through the page count, the scan,
// the decision and, for a split, a shift of later entries and the upper and lower split writes;
// a free takes one pass over the table; a zero size never raises busy. The result strobe follows in
// the cycle busy falls; a new item is taken only while idle, the strobe's cycle included.
// The scan and shift rate is one table entry per cycle, set by the single read port.
// Asynchronous reset leaves one free block of all pages and first fit; the receiver cannot stall.
`include "contiguous_page_allocator_macros.svh"

module contiguous_page_allocator #(
    parameter int TOTAL_PAGES = 256,
    parameter int PAGE_BYTES  = 4096,
    parameter int MAX_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [15:0] requester_pid,
    input  logic [23:0] amount_bytes,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  start_frame,
    output logic [8:0]  pages_granted,
    output logic [8:0]  pages_freed
);

    // Field widths of one table entry, packed as {owner, free, size, start}.
    localparam int SW  = $clog2(TOTAL_PAGES);
    localparam int ZW  = $clog2(TOTAL_PAGES + 1);
    localparam int IW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int DW  = SW + ZW + 17;
    localparam int NW  = cpa_pkg::NEED_W;
    localparam logic [DW-1:0] RST_WORD = {16'd0, 1'b1, ZW'(TOTAL_PAGES), SW'(0)};

    // The page count is the rounded-up byte count times a rounded-up reciprocal of the
    // page size, shifted down; with one guard bit in the reciprocal this is exact for
    // every sum that fits in NW bits.
    localparam int PBW = $clog2(PAGE_BYTES);
    localparam int MW  = NW + 1;
    localparam int PW  = NW + MW;
    localparam int RSH = NW + PBW;
    localparam longint unsigned RECIP =
        ((64'd1 << RSH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
    localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_PICK  = 3'd2;
    localparam logic [2:0] S_DEC   = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_SPHI  = 3'd5;
    localparam logic [2:0] S_SPLO  = 3'd6;
    localparam logic [2:0] S_FREE  = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    policy_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] iss_reg, iss_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] pidx_reg, pidx_next;
    logic [15:0]   pid_reg, pid_next;
    logic [NW-1:0] div_reg, div_next;
    logic          found_reg, found_next;
    logic [IW-1:0] fidx_reg, fidx_next;
    logic [ZW-1:0] fsize_reg, fsize_next;
    logic [SW-1:0] fstart_reg, fstart_next;
    logic [SW-1:0] pstart_reg, pstart_next;
    logic [ZW-1:0] psize_reg, psize_next;
    logic          pfree_reg, pfree_next;
    logic [15:0]   powner_reg, powner_next;
    logic          hprev_reg, hprev_next;
    logic [IW-1:0] w_reg, w_next;
    logic [ZW-1:0] facc_reg, facc_next;
    logic          done_reg, done_next;
    logic [1:0]    status_reg, status_next;
    logic [SW-1:0] frame_reg, frame_next;
    logic [ZW-1:0] granted_reg, granted_next;
    logic [ZW-1:0] freed_reg, freed_next;

    // Memory port.
    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;

    logic [SW-1:0] e_start;
    logic [ZW-1:0] e_size;
    logic          e_free;
    logic [15:0]   e_owner;
    logic          e_mine;
    logic          e_fits;
    logic          issue;
    logic [PW-1:0] prod;
    logic [NW-1:0] quot;
    logic [NW-1:0] need;

    assign e_start = rdata[SW-1:0];
    assign e_size  = rdata[SW +: ZW];
    assign e_free  = rdata[SW + ZW];
    assign e_owner = rdata[SW + ZW + 1 +: 16];
    assign need    = div_reg;
    assign e_mine  = !e_free && (e_owner == pid_reg);
    assign e_fits  = e_free && (NW'(e_size) >= need);
    assign prod    = {{MW{1'b0}}, div_reg} * {{NW{1'b0}}, RECIP_M};
    assign quot    = NW'(prod[PW-1:RSH]);

    cpa_entry_ram #(
        .DEPTH(MAX_ENTRIES),
        .IW(IW),
        .DW(DW),
        .RST_WORD(RST_WORD)
    ) u_ram (
        .clk(clk),
        .rst_n(rst_n),
        .we(we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        iss_next     = iss_reg;
        pend_next    = 1'b0;
        pidx_next    = pidx_reg;
        pid_next     = pid_reg;
        div_next     = div_reg;
        found_next   = found_reg;
        fidx_next    = fidx_reg;
        fsize_next   = fsize_reg;
        fstart_next  = fstart_reg;
        pstart_next  = pstart_reg;
        psize_next   = psize_reg;
        pfree_next   = pfree_reg;
        powner_next  = powner_reg;
        hprev_next   = hprev_reg;
        w_next       = w_reg;
        facc_next    = facc_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        frame_next   = frame_reg;
        granted_next = granted_reg;
        freed_next   = freed_reg;
        we           = 1'b0;
        waddr        = fidx_reg;
        wdata        = {pid_reg, 1'b0, ZW'(need), fstart_reg};
        raddr        = iss_reg[IW-1:0];
        issue        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    pid_next = requester_pid;
                    if (cmd == cpa_pkg::CMD_FREE)
                    begin
                        iss_next   = '0;
                        hprev_next = 1'b0;
                        w_next     = '0;
                        facc_next  = '0;
                        state_next = S_FREE;
                    end
                    else if (amount_bytes == 24'd0)
                    begin
                        done_next    = 1'b1;
                        status_next  = cpa_pkg::ST_ZERO;
                        frame_next   = '0;
                        granted_next = '0;
                        freed_next   = '0;
                    end
                    else
                    begin
                        div_next   = NW'(amount_bytes) + NW'(PAGE_BYTES - 1);
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                // The rounded-up byte count becomes whole pages in this state.
                div_next   = quot;
                iss_next   = '0;
                found_next = 1'b0;
                if (policy_reg == cpa_pkg::POL_UNUSED)
                begin
                    done_next    = 1'b1;
                    status_next  = cpa_pkg::ST_OOM;
                    frame_next   = '0;
                    granted_next = '0;
                    freed_next   = '0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_PICK;
                end
            end

            S_PICK:
            begin
                issue = iss_reg < count_reg;
                if (issue)
                begin
                    iss_next  = iss_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = iss_reg[IW-1:0];
                end
                if (pend_reg && e_fits &&
                    (!found_reg || (policy_reg == cpa_pkg::POL_FIRST) ||
                     ((policy_reg == cpa_pkg::POL_BEST) && (e_size < fsize_reg)) ||
                     ((policy_reg == cpa_pkg::POL_WORST) && (e_size > fsize_reg))))
                begin
                    found_next  = 1'b1;
                    fidx_next   = pidx_reg;
                    fsize_next  = e_size;
                    fstart_next = e_start;
                    if (policy_reg == cpa_pkg::POL_FIRST)
                    begin
                        pend_next  = 1'b0;
                        state_next = S_DEC;
                    end
                end
                if (!issue && !pend_reg)
                begin
                    state_next = S_DEC;
                end
            end

            S_DEC:
            begin
                if (!found_reg)
                begin
                    done_next    = 1'b1;
                    status_next  = cpa_pkg::ST_OOM;
                    frame_next   = '0;
                    granted_next = '0;
                    freed_next   = '0;
                    state_next   = S_IDLE;
                end
                else if (NW'(fsize_reg) > need)
                begin
                    if (count_reg == CW'(MAX_ENTRIES))
                    begin
                        done_next    = 1'b1;
                        status_next  = cpa_pkg::ST_OOM;
                        frame_next   = '0;
                        granted_next = '0;
                        freed_next   = '0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        iss_next   = count_reg;
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    // Exact fit: mark the block taken in place.
                    we           = 1'b1;
                    done_next    = 1'b1;
                    status_next  = cpa_pkg::ST_ALLOC;
                    frame_next   = fstart_reg;
                    granted_next = ZW'(need);
                    freed_next   = '0;
                    state_next   = S_IDLE;
                end
            end

            S_SHIFT:
            begin
                // Move entries up by one, highest first, to open a slot after the block.
                raddr = IW'(iss_reg - 1'b1);
                issue = iss_reg > (CW'(fidx_reg) + 1'b1);
                if (issue)
                begin
                    iss_next  = iss_reg - 1'b1;
                    pend_next = 1'b1;
                    pidx_next = iss_reg[IW-1:0];
                end
                if (pend_reg)
                begin
                    we    = 1'b1;
                    waddr = pidx_reg;
                    wdata = rdata;
                end
                if (!issue && !pend_reg)
                begin
                    state_next = S_SPHI;
                end
            end

            S_SPHI:
            begin
                we         = 1'b1;
                waddr      = fidx_reg + 1'b1;
                wdata      = {16'd0, 1'b1, fsize_reg - ZW'(need), fstart_reg + SW'(need)};
                count_next = count_reg + 1'b1;
                state_next = S_SPLO;
            end

            S_SPLO:
            begin
                we           = 1'b1;
                done_next    = 1'b1;
                status_next  = cpa_pkg::ST_ALLOC;
                frame_next   = fstart_reg;
                granted_next = ZW'(need);
                freed_next   = '0;
                state_next   = S_IDLE;
            end

            S_FREE:
            begin
                // Release and compact in one pass; writes trail the reads.
                issue = iss_reg < count_reg;
                if (issue)
                begin
                    iss_next  = iss_reg + 1'b1;
                    pend_next = 1'b1;
                end
                waddr = w_reg;
                wdata = {powner_reg, pfree_reg, psize_reg, pstart_reg};
                if (pend_reg)
                begin
                    if (e_mine)
                    begin
                        facc_next = facc_reg + e_size;
                    end
                    if (hprev_reg && pfree_reg && (e_free || e_mine))
                    begin
                        psize_next = psize_reg + e_size;
                    end
                    else
                    begin
                        if (hprev_reg)
                        begin
                            we     = 1'b1;
                            w_next = w_reg + 1'b1;
                        end
                        hprev_next  = 1'b1;
                        pstart_next = e_start;
                        psize_next  = e_size;
                        pfree_next  = e_free || e_mine;
                        powner_next = e_mine ? 16'd0 : e_owner;
                    end
                end
                if (!issue && !pend_reg)
                begin
                    we           = 1'b1;
                    count_next   = CW'(w_reg) + 1'b1;
                    done_next    = 1'b1;
                    status_next  = cpa_pkg::ST_FREED;
                    frame_next   = '0;
                    granted_next = '0;
                    freed_next   = facc_reg;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            policy_reg <= cpa_pkg::POL_FIRST;
            count_reg  <= CW'(1);
            iss_reg    <= '0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
            hprev_reg  <= 1'b0;
            w_reg      <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                policy_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            iss_reg   <= iss_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            hprev_reg <= hprev_next;
            w_reg     <= w_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg    <= pidx_next;
        pid_reg     <= pid_next;
        div_reg     <= div_next;
        fidx_reg    <= fidx_next;
        fsize_reg   <= fsize_next;
        fstart_reg  <= fstart_next;
        pstart_reg  <= pstart_next;
        psize_reg   <= psize_next;
        pfree_reg   <= pfree_next;
        powner_reg  <= powner_next;
        facc_reg    <= facc_next;
        status_reg  <= status_next;
        frame_reg   <= frame_next;
        granted_reg <= granted_next;
        freed_reg   <= freed_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign start_frame   = 8'(frame_reg);
    assign pages_granted = 9'(granted_reg);
    assign pages_freed   = 9'(freed_reg);

    // An accepted item keeps the block busy or answers at once.
    `CPA_ASSERT_NEXT(a_accept, clk, rst_n, start && !busy, busy || done)
    // The table never becomes empty nor overflows.
    `CPA_ASSERT_NOW(a_count, clk, rst_n, 1'b1, (count_reg != '0) && (count_reg <= CW'(MAX_ENTRIES)))
    // A free result never reports granted pages.
    `CPA_ASSERT_NOW(a_freed, clk, rst_n, done && (status == cpa_pkg::ST_FREED), pages_granted == 9'd0)
    // An allocation result always grants at least one page.
    `CPA_ASSERT_NOW(a_grant, clk, rst_n, done && (status == cpa_pkg::ST_ALLOC), granted_reg != '0)

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the contiguous page allocator.
// Depends on cpa_pkg and the contiguous_page_allocator top level only.
`timescale 1ns / 100ps

module testbench;

    localparam int TOTAL_PAGES = 256;
    localparam int PAGE_BYTES  = 4096;
    localparam int MAX_ENTRIES = 256;
    localparam int N_RANDOM    = 200;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [15:0] requester_pid;
    logic [23:0] amount_bytes;
    logic        done;
    logic [1:0]  status;
    logic [7:0]  start_frame;
    logic [8:0]  pages_granted;
    logic [8:0]  pages_freed;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] start_frame;
        logic [8:0] pages_granted;
        logic [8:0] pages_freed;
    } alloc_reply_t;

    // One row of the directed table. A row with check_now set carries a reply
    // that can be read off by hand; it is compared with the predictor too.
    typedef struct {
        logic         cmd;
        logic [15:0]  pid;
        logic [23:0]  amount;
        logic         check_now;
        alloc_reply_t reply;
    } directed_row_t;

    // Shadow copy of the block table, kept by the predictor.
    logic [7:0]  blk_start [MAX_ENTRIES];
    logic [8:0]  blk_size  [MAX_ENTRIES];
    logic        blk_free  [MAX_ENTRIES];
    logic [15:0] blk_owner [MAX_ENTRIES];
    int          blk_count;
    logic [1:0]  policy;

    alloc_reply_t pending_replies[$];
    int           fail_count;
    logic [15:0]  live_pids[$];

    contiguous_page_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .requester_pid (requester_pid),
        .amount_bytes  (amount_bytes),
        .done          (done),
        .status        (status),
        .start_frame   (start_frame),
        .pages_granted (pages_granted),
        .pages_freed   (pages_freed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // This limit is many times the slowest correct run, with every sender gap included.
    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void table_reset();
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            blk_start[i] = '0;
            blk_size[i]  = '0;
            blk_free[i]  = 1'b0;
            blk_owner[i] = '0;
        end
        blk_size[0] = 9'(TOTAL_PAGES);
        blk_free[0] = 1'b1;
        blk_count   = 1;
        policy      = cpa_pkg::POL_FIRST;
    endfunction

    // Chooses the block for a request of 'need' pages under the current policy.
    function automatic int choose_block(int need);
        int found;
        int found_size;
        found = -1;
        found_size = 0;
        if (policy != cpa_pkg::POL_FIRST && policy != cpa_pkg::POL_BEST &&
            policy != cpa_pkg::POL_WORST)
            return -1;
        for (int i = 0; i < blk_count; i++)
        begin
            if (!blk_free[i] || int'(blk_size[i]) < need)
                continue;
            if (policy == cpa_pkg::POL_FIRST)
                return i;
            if (found < 0 ||
                (policy == cpa_pkg::POL_BEST && int'(blk_size[i]) < found_size) ||
                (policy == cpa_pkg::POL_WORST && int'(blk_size[i]) > found_size))
            begin
                found = i;
                found_size = blk_size[i];
            end
        end
        return found;
    endfunction

    function automatic void coalesce_free();
        int w;
        w = 0;
        for (int i = 0; i < blk_count; i++)
        begin
            if (w > 0 && blk_free[w-1] && blk_free[i])
                blk_size[w-1] = blk_size[w-1] + blk_size[i];
            else
            begin
                blk_start[w] = blk_start[i];
                blk_size[w]  = blk_size[i];
                blk_free[w]  = blk_free[i];
                blk_owner[w] = blk_owner[i];
                w++;
            end
        end
        blk_count = w;
    endfunction

    // Works out the reply to one request and updates the shadow table.
    function automatic alloc_reply_t serve_request(logic c, logic [15:0] pid,
                                                   logic [23:0] amount);
        alloc_reply_t r;
        int need;
        int k;
        int sz;
        r = '0;
        if (c == cpa_pkg::CMD_FREE)
        begin
            int released;
            released = 0;
            for (int i = 0; i < blk_count; i++)
            begin
                if (!blk_free[i] && blk_owner[i] == pid)
                begin
                    blk_free[i]  = 1'b1;
                    blk_owner[i] = '0;
                    released += blk_size[i];
                end
            end
            coalesce_free();
            r.status      = cpa_pkg::ST_FREED;
            r.pages_freed = 9'(released);
        end
        else if (amount == '0)
            r.status = cpa_pkg::ST_ZERO;
        else
        begin
            need = (int'(amount) + PAGE_BYTES - 1) / PAGE_BYTES;
            k = choose_block(need);
            r.status = cpa_pkg::ST_OOM;
            if (k >= 0)
            begin
                sz = blk_size[k];
                if (sz > need && blk_count < MAX_ENTRIES)
                begin
                    for (int j = blk_count; j > k + 1; j--)
                    begin
                        blk_start[j] = blk_start[j-1];
                        blk_size[j]  = blk_size[j-1];
                        blk_free[j]  = blk_free[j-1];
                        blk_owner[j] = blk_owner[j-1];
                    end
                    blk_start[k+1] = 8'(int'(blk_start[k]) + need);
                    blk_size[k+1]  = 9'(sz - need);
                    blk_free[k+1]  = 1'b1;
                    blk_owner[k+1] = '0;
                    blk_count++;
                    blk_size[k] = 9'(need);
                end
                if (int'(blk_size[k]) == need)
                begin
                    blk_free[k]     = 1'b0;
                    blk_owner[k]    = pid;
                    r.start_frame   = blk_start[k];
                    r.pages_granted = 9'(need);
                    r.status        = cpa_pkg::ST_ALLOC;
                end
            end
        end
        return r;
    endfunction

    // Result side: every strobe is compared field by field with the oldest
    // expected reply. The receiver cannot stall, so nothing is driven here.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            alloc_reply_t want;
            if (pending_replies.size() == 0)
            begin
                $error("result with nothing expected: status %0d", status);
                fail_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, status);
                    fail_count++;
                end
                if (start_frame !== want.start_frame)
                begin
                    $error("start_frame expected %0d actual %0d", want.start_frame,
                           start_frame);
                    fail_count++;
                end
                if (pages_granted !== want.pages_granted)
                begin
                    $error("pages_granted expected %0d actual %0d", want.pages_granted,
                           pages_granted);
                    fail_count++;
                end
                if (pages_freed !== want.pages_freed)
                begin
                    $error("pages_freed expected %0d actual %0d", want.pages_freed,
                           pages_freed);
                    fail_count++;
                end
            end
        end
    end

    // Sends one item: waits a random gap with start low, raises start, holds it
    // until the block takes it, and records the expected reply at the accepting
    // edge. Start stays high after acceptance; the next item either replaces the
    // fields at once or lowers start for its gap, and a drain lowers it too.
    task automatic send_item(logic c, logic [15:0] pid, logic [23:0] amount,
                             logic check_now, alloc_reply_t hand_reply);
        int gap;
        alloc_reply_t r;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        cmd           <= c;
        requester_pid <= pid;
        amount_bytes  <= amount;
        do
            @(posedge clk);
        while (busy);
        r = serve_request(c, pid, amount);
        if (check_now && r !== hand_reply)
        begin
            $error("predictor disagrees with hand-written reply: expected %h got %h",
                   hand_reply, r);
            fail_count++;
        end
        pending_replies.insert(pending_replies.size(), r);
    endtask

    // Waits for every reply and then lets the block settle before a register
    // write; every item has a reply, so the margin is small.
    task automatic drain_and_settle();
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_policy(logic [1:0] value);
        drain_and_settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        policy = value;
        cfg_we <= 1'b0;
    endtask

    // Random allocate size: mostly up to 24 pages, sometimes byte-exact edges or
    // zero, rarely the full range of the field.
    function automatic logic [23:0] random_amount();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return 24'($urandom_range(1, 24 * PAGE_BYTES));
        else if (pick < 15)
            return 24'($urandom_range(1, 4) * PAGE_BYTES + $urandom_range(0, 2) - 1);
        else if (pick < 16)
            return '0;
        else
            return 24'($urandom);
    endfunction

    directed_row_t directed[] = '{
        // Out of memory on the widest request, full table untouched.
        '{cpa_pkg::CMD_ALLOC, 16'h0001, 24'hFFFFFF, 1'b1, '{cpa_pkg::ST_OOM, 8'd0, 9'd0, 9'd0}},
        // Zero size is rejected with its own status.
        '{cpa_pkg::CMD_ALLOC, 16'h0001, 24'h000000, 1'b1, '{cpa_pkg::ST_ZERO, 8'd0, 9'd0, 9'd0}},
        // One byte rounds up to a single page at frame 0.
        '{cpa_pkg::CMD_ALLOC, 16'hFFFF, 24'h000001, 1'b1, '{cpa_pkg::ST_ALLOC, 8'd0, 9'd1, 9'd0}},
        '{cpa_pkg::CMD_ALLOC, 16'h0002, 24'h001000, 1'b1, '{cpa_pkg::ST_ALLOC, 8'd1, 9'd1, 9'd0}},
        '{cpa_pkg::CMD_ALLOC, 16'h0003, 24'h001001, 1'b1, '{cpa_pkg::ST_ALLOC, 8'd2, 9'd2, 9'd0}},
        '{cpa_pkg::CMD_ALLOC, 16'h0002, 24'h004000, 1'b1, '{cpa_pkg::ST_ALLOC, 8'd4, 9'd4, 9'd0}},
        // Free with nothing owned still answers freed.
        '{cpa_pkg::CMD_FREE,  16'h1234, 24'hFFFFFF, 1'b1, '{cpa_pkg::ST_FREED, 8'd0, 9'd0, 9'd0}},
        '{cpa_pkg::CMD_FREE,  16'h0002, 24'h000000, 1'b1, '{cpa_pkg::ST_FREED, 8'd0, 9'd0, 9'd5}},
        '{cpa_pkg::CMD_ALLOC, 16'h0004, 24'h002000, 1'b0, '{cpa_pkg::ST_ALLOC, 8'd0, 9'd0, 9'd0}},
        '{cpa_pkg::CMD_FREE,  16'hFFFF, 24'h000000, 1'b0, '{cpa_pkg::ST_FREED, 8'd0, 9'd0, 9'd0}},
        '{cpa_pkg::CMD_FREE,  16'h0003, 24'h000000, 1'b0, '{cpa_pkg::ST_FREED, 8'd0, 9'd0, 9'd0}},
        '{cpa_pkg::CMD_FREE,  16'h0004, 24'h000000, 1'b0, '{cpa_pkg::ST_FREED, 8'd0, 9'd0, 9'd0}},
        // The whole memory in one block, then nothing more fits.
        '{cpa_pkg::CMD_ALLOC, 16'h5AA5, 24'h100000, 1'b1,
          '{cpa_pkg::ST_ALLOC, 8'd0, 9'd256, 9'd0}},
        '{cpa_pkg::CMD_ALLOC, 16'h0007, 24'h000001, 1'b1, '{cpa_pkg::ST_OOM, 8'd0, 9'd0, 9'd0}},
        '{cpa_pkg::CMD_FREE,  16'h5AA5, 24'h000000, 1'b1,
          '{cpa_pkg::ST_FREED, 8'd0, 9'd0, 9'd256}},
        '{cpa_pkg::CMD_ALLOC, 16'h0000, 24'h100001, 1'b1, '{cpa_pkg::ST_OOM, 8'd0, 9'd0, 9'd0}}
    };

    // Fills the table with single pages owned alternately by two owners until it
    // is full. Freeing one owner leaves isolated single free pages, so the table
    // stays full: an exact fit still succeeds and a two-page request finds nothing.
    task automatic fill_table();
        for (int i = 0; i < TOTAL_PAGES; i++)
            send_item(cpa_pkg::CMD_ALLOC, 16'((i % 2) + 1), 24'(PAGE_BYTES), 1'b0, '0);
        send_item(cpa_pkg::CMD_FREE, 16'h0001, '0, 1'b0, '0);
        send_item(cpa_pkg::CMD_ALLOC, 16'h0BAD, 24'(PAGE_BYTES), 1'b0, '0);
        send_item(cpa_pkg::CMD_ALLOC, 16'h0BAD, 24'(2 * PAGE_BYTES), 1'b0, '0);
        send_item(cpa_pkg::CMD_FREE, 16'h0002, '0, 1'b0, '0);
        send_item(cpa_pkg::CMD_FREE, 16'h0BAD, '0, 1'b0, '0);
    endtask

    // A random phase: mostly allocations for a small set of owners so that
    // frees find blocks, with a free now and then to keep space available.
    task automatic random_phase(int n_items);
        logic [15:0] pid;
        for (int n = 0; n < n_items; n++)
        begin
            if ($urandom_range(0, 3) == 0 && live_pids.size() != 0)
            begin
                int idx;
                idx = $urandom_range(0, live_pids.size() - 1);
                pid = live_pids[idx];
                live_pids.delete(idx);
                send_item(cpa_pkg::CMD_FREE, pid, 24'($urandom), 1'b0, '0);
            end
            else if ($urandom_range(0, 19) == 0)
                send_item(cpa_pkg::CMD_FREE, 16'($urandom), 24'($urandom), 1'b0, '0);
            else
            begin
                pid = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(1, 12));
                live_pids.insert(live_pids.size(), pid);
                send_item(cpa_pkg::CMD_ALLOC, pid, random_amount(), 1'b0, '0);
            end
            // Hold off now and then until all replies are in.
            if ($urandom_range(0, 49) == 0)
                drain_and_settle();
        end
    endtask

    initial
    begin
        fail_count    = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        start         = 1'b0;
        cmd           = cpa_pkg::CMD_ALLOC;
        requester_pid = '0;
        amount_bytes  = '0;
        table_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_item(directed[i].cmd, directed[i].pid, directed[i].amount,
                      directed[i].check_now, directed[i].reply);

        // The unused policy value finds no block at all.
        write_policy(cpa_pkg::POL_UNUSED);
        send_item(cpa_pkg::CMD_ALLOC, 16'h0009, 24'h000001, 1'b1,
                  '{cpa_pkg::ST_OOM, 8'd0, 9'd0, 9'd0});
        write_policy(cpa_pkg::POL_FIRST);
        fill_table();

        // Random traffic under each policy in turn, the extremes included.
        random_phase(N_RANDOM / 4);
        write_policy(cpa_pkg::POL_BEST);
        random_phase(N_RANDOM / 4);
        write_policy(cpa_pkg::POL_WORST);
        random_phase(N_RANDOM / 4);
        write_policy(cpa_pkg::POL_UNUSED);
        random_phase(20);
        write_policy(cpa_pkg::POL_FIRST);
        random_phase(N_RANDOM / 4);

        drain_and_settle();
        repeat (600) @(posedge clk);
        if (fail_count == 0 && pending_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cpa_pkg.sv
hdl/cpa_entry_ram.sv
hdl/contiguous_page_allocator.sv
verif/testbench.sv
